[rtl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package ple_pkg;

  // Fixed field widths of the item formats
  localparam int unsigned PosW      = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CntOutW   = 7;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned MaxDataW  = 64;

  // Defaults for the top-level parameters
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] STS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STS_EMPTY    = 2'd1;
  localparam logic [StatusW-1:0] STS_FULL     = 2'd2;
  localparam logic [StatusW-1:0] STS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [PosW-1:0]  position;
    logic [WordW-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   data_out;
    logic [CntOutW-1:0] entry_count;
  } out_item_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic            act;  // an operation beat was taken this cycle
    logic            ins;  // insert: shift up from pos, load word at pos
    logic            rem;  // remove: shift down from pos
    logic            rd;   // read hit: cell at pos presents its word
    logic [PosW-1:0] pos;  // effective position, already clamped
  } cell_ctrl_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REDUCE = 2'b10
  } state_e;

endpackage

[rtl/ple_if.sv]
// Valid/ready channel interfaces for input and result beats.
// Depends on ple_pkg for the payload types.
`timescale 1ns / 1ps

interface ple_in_if;
  logic              valid;
  logic              ready;
  ple_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ple_out_if;
  logic               valid;
  logic               ready;
  ple_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ple_cell.sv]
// One list slot: holds a word and takes a neighbor's word on insert/remove.
// Depends on ple_pkg for the control struct.
`timescale 1ns / 1ps

module ple_cell #(
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  ple_pkg::cell_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0] word_i,   // word being inserted
  input  logic [DATA_WIDTH-1:0] left_i,   // value of slot IDX-1
  input  logic [DATA_WIDTH-1:0] right_i,  // value of slot IDX+1
  output logic [DATA_WIDTH-1:0] value_o,
  output logic [DATA_WIDTH-1:0] rd_o      // read hit: own word, else zero; held between beats
);
  import ple_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(IDX);

  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;
  logic                  above, at;

  assign above = MyIdx > ctrl_i.pos;
  assign at    = MyIdx == ctrl_i.pos;

  // Next slot value
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (above) begin
        value_d = left_i;
      end else if (at) begin
        value_d = word_i;
      end
    end else if (ctrl_i.rem && (above || at)) begin
      value_d = right_i;
    end
  end

  // Read word is sampled before any shift of the same beat
  always_comb begin
    rd_d = rd_q;
    if (ctrl_i.act) begin
      rd_d = (ctrl_i.rd && at) ? value_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rd_q    <= rd_d;
  end

  assign value_o = value_q;
  assign rd_o    = rd_q;

endmodule

[rtl/positional_list_engine.sv]
// Top level of the positional list engine: controller, count and row of cells.
// Depends on ple_pkg, ple_if (ple_in_if, ple_out_if) and ple_cell.
`timescale 1ns / 1ps

// Usage
//   in_i  : one beat per operation (opcode, position, data_in).
//   out_o : one result beat per operation (status, data_out, entry_count).
//   The list is a row of CAPACITY cells. Insert and remove shift every cell
//   past the position by one slot in the beat's accept cycle; a read makes
//   the addressed cell register its word.
//   The result beat is registered: at the accept the status and the addressed
//   cell's word are registered, and the fold cycle then folds the per-cell
//   read words into the output register. No new operation is taken until
//   the pending one has left its fold cycle.
//   Input ready is high whenever no operation is in its fold cycle, so a new
//   beat is taken while an earlier result still waits in the output register.
//   If the receiver stalls, the pending operation holds in the fold cycle
//   until the output register frees, and input ready stays low meanwhile.
//   Reset empties the list (count zero) and drops any pending result; the
//   cell contents are not cleared and need not be.
module positional_list_engine #(
  parameter int unsigned CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ple_in_if.sink    in_i,
  ple_out_if.source out_o
);
  import ple_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = PosW + 1;

  state_e                state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [StatusW-1:0]    sts_q, sts_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  accept;
  logic                  load_out;
  cell_ctrl_t            ctrl;
  logic [CmpW-1:0]       pos_w, cnt_w;
  logic [MaxDataW-1:0]   word_wide, rd_wide;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_or;

  logic [DATA_WIDTH-1:0] values [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_words [CAPACITY];

  assign in_i.ready = state_q == ST_IDLE;
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == ST_REDUCE) && (!out_valid_q || out_o.ready);

  assign pos_w     = CmpW'(in_i.payload.position);
  assign cnt_w     = CmpW'(cnt_q);
  assign word_wide = MaxDataW'(in_i.payload.data_in);
  assign word      = word_wide[DATA_WIDTH-1:0];

  // Decode the operation against the current count
  always_comb begin
    ctrl     = '0;
    ctrl.act = accept;
    sts_d    = sts_q;
    cnt_d    = cnt_q;
    if (accept) begin
      case (in_i.payload.opcode)
        OP_INSERT: begin
          if (cnt_q == CntW'(CAPACITY)) begin
            sts_d = STS_FULL;
          end else begin
            sts_d    = STS_OK;
            cnt_d    = cnt_q + 1'b1;
            ctrl.ins = 1'b1;
            ctrl.pos = (pos_w >= cnt_w) ? cnt_w[PosW-1:0] : in_i.payload.position;
          end
        end
        OP_REMOVE: begin
          if (cnt_q == '0) begin
            sts_d = STS_EMPTY;
          end else begin
            sts_d    = STS_OK;
            cnt_d    = cnt_q - 1'b1;
            ctrl.rem = 1'b1;
            ctrl.pos = (pos_w < cnt_w - 1'b1) ? in_i.payload.position
                                              : PosW'(cnt_d);
          end
        end
        OP_READ: begin
          if (cnt_q == '0) begin
            sts_d = STS_EMPTY;
          end else if (cnt_q == CntW'(1)) begin
            // single entry answers any position
            sts_d   = STS_OK;
            ctrl.rd = 1'b1;
          end else if (pos_w < cnt_w) begin
            sts_d    = STS_OK;
            ctrl.rd  = 1'b1;
            ctrl.pos = in_i.payload.position;
          end else begin
            sts_d = STS_NOTFOUND;
          end
        end
        default: begin
          sts_d = STS_NOTFOUND;
        end
      endcase
    end
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .word_i  (word),
      .left_i  (values[(g == 0) ? 0 : g - 1]),
      .right_i (values[(g == CAPACITY - 1) ? g : g + 1]),
      .value_o (values[g]),
      .rd_o    (rd_words[g])
    );
  end

  // Fold the per-cell read words; at most one is nonzero
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_words[i];
    end
  end
  assign rd_wide = MaxDataW'(rd_or);

  // Controller
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d       = 1'b1;
      out_d.status      = sts_q;
      out_d.data_out    = rd_wide[WordW-1:0];
      out_d.entry_count = CntOutW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sts_q <= sts_d;
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_REDUCE)
    else $error("accepted beat did not enter fold cycle");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl.ins) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not raise the count");

  a_rem_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl.rem) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("remove did not lower the count");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_REDUCE))
    else $error("result appeared without a pending operation");

endmodule

[dv/tb_positional_list_engine.sv]
// Self-checking testbench for positional_list_engine: directed corner cases, then random
// fill/drain/mix runs with random idle on both channels. Depends on ple_pkg and ple_if.
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int unsigned CAP         = CAPACITY_DEF;
  localparam int unsigned ITEMS_TOTAL = 1050;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef enum int unsigned {RUN_FILL, RUN_DRAIN, RUN_MIX} run_mode_e;

  // Shadow copy of the list: predicts one result per accepted beat and
  // checks the result beats against it in order.
  class list_shadow;
    logic [WordW-1:0] words [CAP];
    int unsigned      fill;
    out_item_t        due_results [$];
    int unsigned      mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void apply_op(in_item_t op);
      out_item_t   res;
      int unsigned pos;
      pos = op.position;
      res = '0;
      res.status = STS_OK;
      case (op.opcode)
        OP_INSERT: begin
          if (fill >= CAP) begin
            res.status = STS_FULL;
          end else begin
            if (pos >= fill) begin
              words[fill] = op.data_in;
            end else begin
              for (int unsigned i = fill; i > pos; i--) words[i] = words[i-1];
              words[pos] = op.data_in;
            end
            fill++;
          end
        end
        OP_REMOVE: begin
          if (fill == 0) begin
            res.status = STS_EMPTY;
          end else begin
            // past the end takes the last entry, no shift needed
            if (pos < fill - 1) begin
              for (int unsigned i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            end
            fill--;
          end
        end
        OP_READ: begin
          if (fill == 0) begin
            res.status = STS_EMPTY;
          end else if (fill == 1) begin
            // a lone entry answers any position
            res.data_out = words[0];
          end else if (pos < fill) begin
            res.data_out = words[pos];
          end else begin
            res.status = STS_NOTFOUND;
          end
        end
        default: begin
          res.status = STS_NOTFOUND;
        end
      endcase
      res.entry_count = fill[CntOutW-1:0];
      due_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d data %h count %0d",
                 $time, got.status, got.data_out, got.entry_count);
        mismatches++;
        return;
      end
      exp = due_results.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, exp.status, got.status);
        mismatches++;
      end
      if (got.data_out !== exp.data_out) begin
        $display("%0t: data_out mismatch: expected %h, got %h",
                 $time, exp.data_out, got.data_out);
        mismatches++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, got %0d",
                 $time, exp.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ple_in_if  in_if ();
  ple_out_if out_if ();

  positional_list_engine #(
    .CAPACITY   (CAP),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  list_shadow  sb = new();
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int unsigned sent_total;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  // Beat monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.apply_op(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    end
  end

  // Result side: ready with random stall bursts
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Entered and left at a falling edge; valid stays high into the next beat
  task automatic send_op(logic [OpW-1:0] opc, logic [PosW-1:0] pos, logic [WordW-1:0] word);
    in_item_t beat;
    beat.opcode   = opc;
    beat.position = pos;
    beat.data_in  = word;
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= beat;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    @(negedge clk_i);
    sent_total++;
  endtask

  function automatic logic [PosW-1:0] pick_pos();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return PosW'($urandom_range(0, sb.fill));
    if (sel == 6) return (sb.fill == 0) ? '0 : PosW'(sb.fill - 1);
    if (sel == 7) return PosW'(sb.fill);
    return PosW'($urandom_range(0, 255));
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  task automatic random_run(run_mode_e mode, int unsigned n_items);
    int unsigned r;
    logic [OpW-1:0] opc;
    for (int unsigned k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      case (mode)
        RUN_FILL:  opc = (r < 70) ? OP_INSERT : (r < 82) ? OP_REMOVE :
                         (r < 97) ? OP_READ : OP_UNUSED;
        RUN_DRAIN: opc = (r < 70) ? OP_REMOVE : (r < 82) ? OP_INSERT :
                         (r < 97) ? OP_READ : OP_UNUSED;
        default:   opc = (r < 30) ? OP_INSERT : (r < 55) ? OP_REMOVE :
                         (r < 97) ? OP_READ : OP_UNUSED;
      endcase
      send_op(opc, pick_pos(), pick_word());
    end
  endtask

  // Fill up, push against full, read the full list
  task automatic fill_to_full();
    while (sb.fill < CAP) send_op(OP_INSERT, pick_pos(), pick_word());
    repeat (6) send_op(OP_INSERT, pick_pos(), pick_word());
    repeat (20) send_op(OP_READ, PosW'($urandom_range(0, 255)), pick_word());
    send_op(OP_READ, PosW'(CAP - 1), '0);
    send_op(OP_READ, PosW'(CAP), '0);
  endtask

  // Empty out, push against empty
  task automatic drain_to_empty();
    while (sb.fill > 0) begin
      if ($urandom_range(0, 3) == 0) send_op(OP_READ, pick_pos(), pick_word());
      else send_op(OP_REMOVE, pick_pos(), pick_word());
    end
    repeat (4) send_op(OP_REMOVE, PosW'($urandom_range(0, 255)), pick_word());
    repeat (2) send_op(OP_READ, PosW'($urandom_range(0, 255)), pick_word());
  endtask

  // Stimulus
  initial begin
    run_mode_e mode;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    sent_total     = 0;
    rst_ni         = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners
    send_op(OP_READ,   8'd0,   32'h0);         // read on empty
    send_op(OP_REMOVE, 8'd255, 32'hFFFF_FFFF); // remove on empty
    send_op(OP_UNUSED, 8'd255, 32'hFFFF_FFFF); // unused opcode
    send_op(OP_INSERT, 8'd255, 32'hFFFF_FFFF); // append past end
    send_op(OP_READ,   8'd200, 32'h0);         // lone entry, far position
    send_op(OP_READ,   8'd0,   32'h0);
    send_op(OP_INSERT, 8'd0,   32'h0000_0000); // insert at head
    send_op(OP_READ,   8'd1,   32'h0);
    send_op(OP_READ,   8'd2,   32'h0);         // just past the end
    send_op(OP_READ,   8'd255, 32'h0);
    send_op(OP_INSERT, 8'd1,   32'hA5A5_A5A5); // insert in the middle
    send_op(OP_INSERT, 8'd3,   32'h5A5A_5A5A); // insert at exactly count
    send_op(OP_READ,   8'd1,   32'h0);
    send_op(OP_READ,   8'd3,   32'h0);
    send_op(OP_REMOVE, 8'd1,   32'h0);         // remove from the middle
    send_op(OP_READ,   8'd1,   32'h0);
    send_op(OP_REMOVE, 8'd255, 32'h0);         // remove past end takes the last
    send_op(OP_REMOVE, 8'd1,   32'h0);         // remove at count-1
    send_op(OP_READ,   8'd77,  32'h0);
    send_op(OP_REMOVE, 8'd0,   32'h0);         // back to empty
    send_op(OP_READ,   8'd0,   32'h0);
    send_op(OP_INSERT, 8'd0,   32'h8000_0001);
    send_op(OP_REMOVE, 8'd128, 32'h0);

    // Full and empty walls, with idle on both sides
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    fill_to_full();
    drain_to_empty();

    // Let every result drain before sending more
    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat ($urandom_range(1, 12)) @(negedge clk_i);

    // Random runs with random idle settings
    while (sent_total < ITEMS_TOTAL - QUIET_TAIL) begin
      src_gaps_on    = $urandom_range(0, 2) != 0;
      sink_stalls_on = $urandom_range(0, 2) != 0;
      mode = run_mode_e'($urandom_range(0, 2));
      random_run(mode, $urandom_range(20, 80));
    end

    // Closing stretch at full rate
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    while (sent_total < ITEMS_TOTAL) random_run(RUN_MIX, 10);

    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
